// File: sv/scatter_gather_extent_merge_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the extent merge block
// Concurrent checks are active in simulation and compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef SCATTER_GATHER_EXTENT_MERGE_MACROS_SVH
`define SCATTER_GATHER_EXTENT_MERGE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, ignored while reset is held.
`define SGEM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, ignored while reset is held.
`define SGEM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SGEM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SGEM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: sv/sgem_pkg.sv
// ----------------------------------------------------------------------------
// sgem_pkg
// Shared widths, codes and types of the scatter-gather extent merge block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgem_pkg;

    // Field widths.
    localparam int unsigned KIND_W = 2;
    localparam int unsigned ADDR_W = 64;
    localparam int unsigned OFF_W  = 63;
    localparam int unsigned LEN_W  = 48;
    localparam int unsigned STAT_W = 2;

    // Default list capacity and depth of the command queue.
    localparam int unsigned MAX_REGIONS_DEF = 16;
    localparam int unsigned QUEUE_DEPTH     = 2;

    // Input kind codes.
    localparam logic [KIND_W-1:0] KIND_LOAD_MEM    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_STREAM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START       = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd2;

    // Command classes after the front end has decoded an input.
    typedef enum logic [1:0] {
        CMD_LOAD_MEM,
        CMD_LOAD_STREAM,
        CMD_START
    } t_cmd;

    // One queued command.
    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  length;
    } t_qent;

    // Write side of the queue: an entry and its push strobe.
    typedef struct packed {
        logic  push;
        t_qent ent;
    } t_qwr;

    // Read side of the queue: head entry and whether it is present.
    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qhead;

endpackage

`default_nettype wire

// File: sv/sgem_channels.sv
// ----------------------------------------------------------------------------
// sgem channels
// Valid/ready interfaces for the request and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Request channel: region loads and merge starts.
interface sgem_req_if;
    logic                              valid;
    logic                              ready;
    logic [sgem_pkg::KIND_W-1:0]       kind;
    logic [sgem_pkg::ADDR_W-1:0]       base;
    logic [sgem_pkg::LEN_W-1:0]        length;

    modport source (output valid, kind, base, length, input ready);
    modport sink   (input valid, kind, base, length, output ready);
endinterface

// Result channel: one extent per transfer.
interface sgem_res_if;
    logic                              valid;
    logic                              ready;
    logic [sgem_pkg::ADDR_W-1:0]       mem_address;
    logic [sgem_pkg::OFF_W-1:0]        stream_offset;
    logic [sgem_pkg::LEN_W-1:0]        extent_size;
    logic                              last;
    logic [sgem_pkg::STAT_W-1:0]       status;

    modport source (output valid, mem_address, stream_offset, extent_size, last, status,
                    input ready);
    modport sink   (input valid, mem_address, stream_offset, extent_size, last, status,
                    output ready);
endinterface

`default_nettype wire

// File: sv/sgem_front.sv
// ----------------------------------------------------------------------------
// sgem_front
// Accepts request transfers, decodes the kind and pushes commands to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgem_front (
    sgem_req_if.sink          i_req,
    input  logic              i_q_full,
    output sgem_pkg::t_qwr    o_qwr
);

    logic w_accept;

    // A transfer is taken whenever the queue has room.
    assign i_req.ready = !i_q_full;
    assign w_accept    = i_req.valid && !i_q_full;

    // Decode the kind; the unused code is accepted and dropped.
    always_comb begin
        o_qwr.push       = 1'b0;
        o_qwr.ent.cmd    = sgem_pkg::CMD_LOAD_MEM;
        o_qwr.ent.base   = i_req.base;
        o_qwr.ent.length = i_req.length;
        case (i_req.kind)
            sgem_pkg::KIND_LOAD_MEM: begin
                o_qwr.push    = w_accept;
                o_qwr.ent.cmd = sgem_pkg::CMD_LOAD_MEM;
            end
            sgem_pkg::KIND_LOAD_STREAM: begin
                o_qwr.push    = w_accept;
                o_qwr.ent.cmd = sgem_pkg::CMD_LOAD_STREAM;
            end
            sgem_pkg::KIND_START: begin
                o_qwr.push    = w_accept;
                o_qwr.ent.cmd = sgem_pkg::CMD_START;
            end
            default: begin
                o_qwr.push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/sgem_queue.sv
// ----------------------------------------------------------------------------
// sgem_queue
// Short command queue that decouples the front end from the merge engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgem_queue #(
    parameter int unsigned DEPTH = sgem_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sgem_pkg::t_qwr    i_qwr,
    input  logic              i_pop,
    output logic              o_full,
    output sgem_pkg::t_qhead  o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sgem_pkg::t_qent  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_full       = (r_cnt == CNT_FULL);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.ent   = r_mem[r_rd_ptr];
    assign w_push       = i_qwr.push && !o_full;
    assign w_pop        = i_pop && o_head.valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_qwr.ent;
        end
    end

endmodule

`default_nettype wire

// File: sv/sgem_back.sv
// ----------------------------------------------------------------------------
// sgem_back
// Region lists and the merge engine that walks them and emits extents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "scatter_gather_extent_merge_macros.svh"

module sgem_back #(
    parameter int unsigned MAX_REGIONS = sgem_pkg::MAX_REGIONS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sgem_pkg::t_qhead  i_head,
    output logic              o_pop,
    sgem_res_if.source        o_res
);

    localparam int unsigned ADDR_W   = sgem_pkg::ADDR_W;
    localparam int unsigned OFF_W    = sgem_pkg::OFF_W;
    localparam int unsigned LEN_W    = sgem_pkg::LEN_W;
    localparam int unsigned STAT_W   = sgem_pkg::STAT_W;
    localparam int unsigned CNT_W    = $clog2(MAX_REGIONS + 1);
    localparam int unsigned IDX_W    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int unsigned MAX_OUT  = 2 * MAX_REGIONS - 1;
    localparam int unsigned STEP_W   = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_REGIONS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_OUT - 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Region stores.
    logic [ADDR_W-1:0] mem_addr_store   [MAX_REGIONS];
    logic [LEN_W-1:0]  mem_len_store    [MAX_REGIONS];
    logic [OFF_W-1:0]  stream_off_store [MAX_REGIONS];
    logic [LEN_W-1:0]  stream_len_store [MAX_REGIONS];

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_m_cnt, n_m_cnt;
    logic [CNT_W-1:0]  r_s_cnt, n_s_cnt;
    logic              r_ovf, n_ovf;
    logic [CNT_W-1:0]  r_mi, n_mi;
    logic [CNT_W-1:0]  r_si, n_si;
    logic [STEP_W-1:0] r_n, n_n;
    logic              r_m_fresh, n_m_fresh;
    logic              r_s_fresh, n_s_fresh;
    logic [STAT_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0] r_cm_addr, n_cm_addr;
    logic [LEN_W-1:0]  r_cm_len, n_cm_len;
    logic [OFF_W-1:0]  r_cs_off, n_cs_off;
    logic [LEN_W-1:0]  r_cs_len, n_cs_len;

    // Registered read data of the stores.
    logic [ADDR_W-1:0] r_mrd_addr;
    logic [LEN_W-1:0]  r_mrd_len;
    logic [OFF_W-1:0]  r_srd_off;
    logic [LEN_W-1:0]  r_srd_len;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    logic [OFF_W-1:0]  r_out_off, n_out_off;
    logic [LEN_W-1:0]  r_out_size, n_out_size;
    logic              r_out_last, n_out_last;
    logic [STAT_W-1:0] r_out_status, n_out_status;

    logic              w_can_emit, w_mem_we, w_str_we;
    logic [ADDR_W-1:0] w_cur_ma;
    logic [LEN_W-1:0]  w_cur_ml;
    logic [OFF_W-1:0]  w_cur_so;
    logic [LEN_W-1:0]  w_cur_sl;
    logic              w_oom, w_oos, w_eq, w_lt, w_adv_m, w_adv_s, w_done;

    assign o_res.valid         = r_out_valid;
    assign o_res.mem_address   = r_out_addr;
    assign o_res.stream_offset = r_out_off;
    assign o_res.extent_size   = r_out_size;
    assign o_res.last          = r_out_last;
    assign o_res.status        = r_out_status;

    assign w_can_emit = !r_out_valid || o_res.ready;

    // Current regions: straight from the read port just after an advance.
    assign w_cur_ma = r_m_fresh ? r_mrd_addr : r_cm_addr;
    assign w_cur_ml = r_m_fresh ? r_mrd_len  : r_cm_len;
    assign w_cur_so = r_s_fresh ? r_srd_off  : r_cs_off;
    assign w_cur_sl = r_s_fresh ? r_srd_len  : r_cs_len;

    // One merge step: compare lengths and decide which side advances.
    assign w_oom   = (r_mi + CNT_W'(1)) >= r_m_cnt;
    assign w_oos   = (r_si + CNT_W'(1)) >= r_s_cnt;
    assign w_eq    = (w_cur_ml == w_cur_sl);
    assign w_lt    = (w_cur_ml < w_cur_sl);
    assign w_adv_m = w_eq || w_lt;
    assign w_adv_s = !w_lt;
    assign w_done  = (w_oom && w_adv_m) || (w_oos && w_adv_s) || (r_n == STEP_LAST);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state      = r_state;
        n_m_cnt      = r_m_cnt;
        n_s_cnt      = r_s_cnt;
        n_ovf        = r_ovf;
        n_mi         = r_mi;
        n_si         = r_si;
        n_n          = r_n;
        n_m_fresh    = r_m_fresh;
        n_s_fresh    = r_s_fresh;
        n_status     = r_status;
        n_cm_addr    = r_cm_addr;
        n_cm_len     = r_cm_len;
        n_cs_off     = r_cs_off;
        n_cs_len     = r_cs_len;
        n_out_valid  = o_res.ready ? 1'b0 : r_out_valid;
        n_out_addr   = r_out_addr;
        n_out_off    = r_out_off;
        n_out_size   = r_out_size;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        o_pop        = 1'b0;
        w_mem_we     = 1'b0;
        w_str_we     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    case (i_head.ent.cmd)
                        sgem_pkg::CMD_LOAD_MEM: begin
                            o_pop = 1'b1;
                            if (r_m_cnt < CNT_MAX) begin
                                w_mem_we = 1'b1;
                                n_m_cnt  = r_m_cnt + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        sgem_pkg::CMD_LOAD_STREAM: begin
                            o_pop = 1'b1;
                            if (r_s_cnt < CNT_MAX) begin
                                w_str_we = 1'b1;
                                n_s_cnt  = r_s_cnt + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        sgem_pkg::CMD_START: begin
                            if (r_m_cnt == '0 || r_s_cnt == '0) begin
                                // Empty list: a single error result, then clear.
                                if (w_can_emit) begin
                                    o_pop        = 1'b1;
                                    n_out_valid  = 1'b1;
                                    n_out_addr   = '0;
                                    n_out_off    = '0;
                                    n_out_size   = '0;
                                    n_out_last   = 1'b1;
                                    n_out_status = sgem_pkg::STATUS_EMPTY;
                                    n_m_cnt      = '0;
                                    n_s_cnt      = '0;
                                    n_ovf        = 1'b0;
                                end
                            end else begin
                                // Fetch the first region of each list.
                                o_pop     = 1'b1;
                                n_state   = ST_RUN;
                                n_mi      = '0;
                                n_si      = '0;
                                n_n       = '0;
                                n_m_fresh = 1'b1;
                                n_s_fresh = 1'b1;
                                n_status  = r_ovf ? sgem_pkg::STATUS_OVERFLOW
                                                  : sgem_pkg::STATUS_OK;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (w_can_emit) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = w_cur_ma;
                    n_out_off    = w_cur_so;
                    n_out_size   = w_adv_m ? w_cur_ml : w_cur_sl;
                    n_out_last   = w_done;
                    n_out_status = r_status;
                    n_n          = r_n + STEP_W'(1);
                    // Memory side: advance to the next region or split.
                    if (w_adv_m) begin
                        n_m_fresh = 1'b1;
                        if (!w_oom) begin
                            n_mi = r_mi + CNT_W'(1);
                        end
                    end else begin
                        n_m_fresh = 1'b0;
                        n_cm_len  = w_cur_ml - w_cur_sl;
                        n_cm_addr = w_cur_ma + ADDR_W'(w_cur_sl);
                    end
                    // Stream side: advance to the next region or split.
                    if (w_adv_s) begin
                        n_s_fresh = 1'b1;
                        if (!w_oos) begin
                            n_si = r_si + CNT_W'(1);
                        end
                    end else begin
                        n_s_fresh = 1'b0;
                        n_cs_len  = w_cur_sl - w_cur_ml;
                        n_cs_off  = w_cur_so + OFF_W'(w_cur_ml);
                    end
                    if (w_done) begin
                        n_state = ST_IDLE;
                        n_m_cnt = '0;
                        n_s_cnt = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_m_cnt     <= '0;
            r_s_cnt     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_m_cnt     <= n_m_cnt;
            r_s_cnt     <= n_s_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_mi         <= n_mi;
        r_si         <= n_si;
        r_n          <= n_n;
        r_m_fresh    <= n_m_fresh;
        r_s_fresh    <= n_s_fresh;
        r_status     <= n_status;
        r_cm_addr    <= n_cm_addr;
        r_cm_len     <= n_cm_len;
        r_cs_off     <= n_cs_off;
        r_cs_len     <= n_cs_len;
        r_out_addr   <= n_out_addr;
        r_out_off    <= n_out_off;
        r_out_size   <= n_out_size;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    // Memory region store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_addr_store[r_m_cnt[IDX_W-1:0]] <= i_head.ent.base;
            mem_len_store[r_m_cnt[IDX_W-1:0]]  <= i_head.ent.length;
        end
        r_mrd_addr <= mem_addr_store[n_mi[IDX_W-1:0]];
        r_mrd_len  <= mem_len_store[n_mi[IDX_W-1:0]];
    end

    // Stream region store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_str_we) begin
            stream_off_store[r_s_cnt[IDX_W-1:0]] <= i_head.ent.base[OFF_W-1:0];
            stream_len_store[r_s_cnt[IDX_W-1:0]] <= i_head.ent.length;
        end
        r_srd_off <= stream_off_store[n_si[IDX_W-1:0]];
        r_srd_len <= stream_len_store[n_si[IDX_W-1:0]];
    end

    // The walk never indexes past the loaded part of either list.
    `SGEM_ASSERT_IMP(a_index_in_list, i_clk, i_rst_n, (r_state == ST_RUN), (r_mi < r_m_cnt && r_si < r_s_cnt), "region index beyond loaded list")
    // A walk only runs with both lists holding regions.
    `SGEM_ASSERT_IMP(a_run_nonempty, i_clk, i_rst_n, (r_state == ST_RUN), (r_m_cnt != '0 && r_s_cnt != '0), "merge running on an empty list")
    // Fill counts stay within capacity.
    `SGEM_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, (r_m_cnt <= CNT_MAX && r_s_cnt <= CNT_MAX), "region count above capacity")
    // The end of a walk leaves both lists and the overflow flag cleared.
    `SGEM_ASSERT_NXT(a_run_clears, i_clk, i_rst_n, (r_state == ST_RUN && n_state == ST_IDLE), (r_m_cnt == '0 && r_s_cnt == '0 && !r_ovf), "lists not cleared after merge")

endmodule

`default_nettype wire

// File: sv/scatter_gather_extent_merge.sv
// ----------------------------------------------------------------------------
// scatter_gather_extent_merge
// Merges a memory region list with a stream region list into extents.
// ----------------------------------------------------------------------------
// Region loads are taken one per cycle while the queue has room and the merge
// engine is idle. A start with an empty list gives its single error result.
// A start over m memory and s stream regions emits at most m + s - 1 extents,
// one per cycle while the result channel keeps up, after the first read of
// the region stores; the registered read port of each store is what sets
// this pace, the next region being fetched while the current extent is
// emitted. A two-entry command queue sits between the request channel and
// the engine, so up to two further requests are still taken while the
// engine waits on the result channel. A result register holds each extent
// until it is taken; the engine computes the next extent in the cycle that
// the previous one is taken and stalls while one is waiting.
`timescale 1ns / 1ps
`default_nettype none

module scatter_gather_extent_merge #(
    parameter int unsigned MAX_REGIONS = sgem_pkg::MAX_REGIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sgem_req_if.sink    i_req,
    sgem_res_if.source  o_res
);

    sgem_pkg::t_qwr   w_qwr;
    sgem_pkg::t_qhead w_head;
    logic             w_q_full;
    logic             w_pop;

    // Request decode.
    sgem_front u_front (
        .i_req    (i_req),
        .i_q_full (w_q_full),
        .o_qwr    (w_qwr)
    );

    // Command queue.
    sgem_queue #(
        .DEPTH (sgem_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (w_qwr),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_head  (w_head)
    );

    // Region lists and merge engine.
    sgem_back #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
